[sv/nbbc_pkg.sv]
// shared types and constants for the net bounding box cost block
package nbbc_pkg;

    localparam int SPAN_W  = 16;
    localparam int COUNT_W = 11;
    localparam int WGT_W   = 16;
    localparam int PROD_W  = SPAN_W + WGT_W;
    localparam int FRAC_W  = 8;
    localparam int COST_W  = 25;
    localparam int TOTAL_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [WGT_W-1:0]   WGT_RESET  = 16'd256;

    typedef struct packed {
        logic [COUNT_W-1:0] left;
        logic [COUNT_W-1:0] right;
        logic [COUNT_W-1:0] bottom;
        logic [COUNT_W-1:0] top;
    } t_counts;

    localparam int COUNTS_W = $bits(t_counts);

endpackage

[sv/net_bounding_box_cost_core.sv]
// top level of the net bounding box cost block
//
//  channel   direction  handshake                payload
//  pin in    input      i_in_valid / o_in_stall  i_pin_x, i_pin_y, i_first_pin,
//                                                i_last_pin, i_net_ignored, i_pass_start
//  result    output     o_out_valid / i_out_stall o_span_x .. o_total_cost
//  config    input      i_cfg_we                 i_cfg_wdata (vertical weight)
//
// one pin per cycle unless o_in_stall is high; box and edge counts update in the front end in the cycle of the transfer
// with the back end free, a result moves from its last pin transfer to the output register
// through the queue write at the transfer, then span, multiply, cost add and total add
// synchronous active-low reset; the weight returns to 1.0, box, counts and total to zero
// o_in_stall rises only when the result queue is full; the back end stalls on its own
module net_bounding_box_cost_core #(
    parameter int COORD_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nbbc_pkg::WGT_W-1:0]         i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [COORD_BITS-1:0]       i_pin_x,
    input  logic signed [COORD_BITS-1:0]       i_pin_y,
    input  logic                               i_first_pin,
    input  logic                               i_last_pin,
    input  logic                               i_net_ignored,
    input  logic                               i_pass_start,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [nbbc_pkg::SPAN_W-1:0]        o_span_x,
    output logic [nbbc_pkg::SPAN_W-1:0]        o_span_y,
    output logic [nbbc_pkg::COUNT_W-1:0]       o_left_count,
    output logic [nbbc_pkg::COUNT_W-1:0]       o_right_count,
    output logic [nbbc_pkg::COUNT_W-1:0]       o_bottom_count,
    output logic [nbbc_pkg::COUNT_W-1:0]       o_top_count,
    output logic [nbbc_pkg::COST_W-1:0]        o_net_cost,
    output logic [nbbc_pkg::TOTAL_W-1:0]       o_total_cost
);
    import nbbc_pkg::*;

    localparam int REC_W = 4 * COORD_BITS + COUNTS_W + 1;

    logic             w_accept;
    logic             w_push, w_pop, w_empty, w_full;
    logic [REC_W-1:0] w_push_data, w_q_data;
    t_counts          w_counts;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    nbbc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_pin_x       (i_pin_x),
        .i_pin_y       (i_pin_y),
        .i_first_pin   (i_first_pin),
        .i_last_pin    (i_last_pin),
        .i_net_ignored (i_net_ignored),
        .i_pass_start  (i_pass_start),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    nbbc_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    nbbc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_data     (w_q_data),
        .i_q_empty    (w_empty),
        .o_q_pop      (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_span_x     (o_span_x),
        .o_span_y     (o_span_y),
        .o_counts     (w_counts),
        .o_net_cost   (o_net_cost),
        .o_total_cost (o_total_cost)
    );

    assign o_left_count   = w_counts.left;
    assign o_right_count  = w_counts.right;
    assign o_bottom_count = w_counts.bottom;
    assign o_top_count    = w_counts.top;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("result queue read while empty");

    a_push_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_accept && i_last_pin && !i_net_ignored))
        else $error("queue write without a counted last pin transfer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

[sv/nbbc_front.sv]
// front end: bounding box and edge count tracking, one pin per cycle
module nbbc_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic signed [COORD_BITS-1:0] i_pin_x,
    input  logic signed [COORD_BITS-1:0] i_pin_y,
    input  logic                         i_first_pin,
    input  logic                         i_last_pin,
    input  logic                         i_net_ignored,
    input  logic                         i_pass_start,
    output logic                         o_push,
    output logic [4*COORD_BITS+nbbc_pkg::COUNTS_W:0] o_push_data
);
    import nbbc_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] mn;
        logic signed [COORD_BITS-1:0] mx;
        logic [COUNT_W-1:0]           lo;
        logic [COUNT_W-1:0]           hi;
    } t_axis;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    function automatic t_axis axis_next(input logic signed [COORD_BITS-1:0] v,
                                        input t_axis cur);
        t_axis nx;
        nx = cur;
        if (v < cur.mn) begin
            nx.mn = v;
            nx.lo = COUNT_W'(1);
        end else if (v == cur.mn) begin
            // a degenerate box bumps both edges
            nx.lo = bump(cur.lo);
            if (v == cur.mx) begin
                nx.hi = bump(cur.hi);
            end
        end else if (v > cur.mx) begin
            nx.mx = v;
            nx.hi = COUNT_W'(1);
        end else if (v == cur.mx) begin
            nx.hi = bump(cur.hi);
        end
        return nx;
    endfunction

    t_axis r_ax, n_ax;
    t_axis r_ay, n_ay;
    logic  r_clear_pend, n_clear_pend;
    logic  w_counted;

    assign w_counted = i_accept && !i_net_ignored;

    always_comb begin
        n_ax = r_ax;
        n_ay = r_ay;
        if (w_counted) begin
            if (i_first_pin) begin
                n_ax = '{mn: i_pin_x, mx: i_pin_x, lo: COUNT_W'(1), hi: COUNT_W'(1)};
                n_ay = '{mn: i_pin_y, mx: i_pin_y, lo: COUNT_W'(1), hi: COUNT_W'(1)};
            end else begin
                n_ax = axis_next(i_pin_x, r_ax);
                n_ay = axis_next(i_pin_y, r_ay);
            end
        end
    end

    // a total clear waits here until the next net result carries it
    always_comb begin
        n_clear_pend = r_clear_pend;
        if (o_push) begin
            n_clear_pend = 1'b0;
        end else if (i_accept && i_pass_start) begin
            n_clear_pend = 1'b1;
        end
    end

    assign o_push = w_counted && i_last_pin;
    assign o_push_data = {n_ax.mn, n_ax.mx, n_ay.mn, n_ay.mx,
                          n_ax.lo, n_ax.hi, n_ay.lo, n_ay.hi,
                          r_clear_pend || i_pass_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax         <= '0;
            r_ay         <= '0;
            r_clear_pend <= 1'b0;
        end else begin
            r_ax         <= n_ax;
            r_ay         <= n_ay;
            r_clear_pend <= n_clear_pend;
        end
    end

endmodule

[sv/nbbc_queue.sv]
// small register queue between the front end and the cost pipeline
module nbbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import nbbc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[sv/nbbc_back.sv]
// back end: spans, weighted cost and saturating running total
module nbbc_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [nbbc_pkg::WGT_W-1:0]               i_cfg_wdata,
    input  logic [4*COORD_BITS+nbbc_pkg::COUNTS_W:0] i_q_data,
    input  logic                                     i_q_empty,
    output logic                                     o_q_pop,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [nbbc_pkg::SPAN_W-1:0]              o_span_x,
    output logic [nbbc_pkg::SPAN_W-1:0]              o_span_y,
    output nbbc_pkg::t_counts                        o_counts,
    output logic [nbbc_pkg::COST_W-1:0]              o_net_cost,
    output logic [nbbc_pkg::TOTAL_W-1:0]             o_total_cost
);
    import nbbc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = (CB + 1 > SPAN_W) ? CB + 1 : SPAN_W;

    logic signed [CB-1:0] w_xmin, w_xmax, w_ymin, w_ymax;
    t_counts              w_counts;
    logic                 w_clear;
    logic [DW-1:0]        w_dx, w_dy;

    assign {w_xmin, w_xmax, w_ymin, w_ymax, w_counts, w_clear} = i_q_data;
    // max is never below min, so the difference is nonnegative
    assign w_dx = {{(DW-CB){w_xmax[CB-1]}}, w_xmax} - {{(DW-CB){w_xmin[CB-1]}}, w_xmin};
    assign w_dy = {{(DW-CB){w_ymax[CB-1]}}, w_ymax} - {{(DW-CB){w_ymin[CB-1]}}, w_ymin};

    logic [WGT_W-1:0] r_weight;

    logic               r_v1, r_v2, r_v3;
    logic [SPAN_W-1:0]  r1_sx, r1_sy, r2_sx, r2_sy, r3_sx, r3_sy;
    t_counts            r1_cnt, r2_cnt, r3_cnt;
    logic               r1_clr, r2_clr, r3_clr;
    logic [PROD_W-1:0]  r2_prod;
    logic [COST_W-1:0]  r3_cost;
    logic               w_en1, w_en2, w_en3, w_en4;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_base;

    // each stage moves when the one after it is free or moving
    assign w_en4   = !o_valid || !i_stall;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_q_pop = !i_q_empty && w_en1;

    assign w_base = r3_clr ? '0 : o_total_cost;
    assign w_sum  = {1'b0, w_base} + (TOTAL_W + 1)'(r3_cost);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WGT_RESET;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_sx  <= w_dx[SPAN_W-1:0];
            r1_sy  <= w_dy[SPAN_W-1:0];
            r1_cnt <= w_counts;
            r1_clr <= w_clear;
        end
        if (w_en2) begin
            r2_prod <= PROD_W'(r_weight) * PROD_W'(r1_sy);
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_cnt  <= r1_cnt;
            r2_clr  <= r1_clr;
        end
        if (w_en3) begin
            r3_cost <= COST_W'(r2_sx) + COST_W'(r2_prod[PROD_W-1:FRAC_W]);
            r3_sx   <= r2_sx;
            r3_sy   <= r2_sy;
            r3_cnt  <= r2_cnt;
            r3_clr  <= r2_clr;
        end
        if (w_en4 && r_v3) begin
            o_span_x   <= r3_sx;
            o_span_y   <= r3_sy;
            o_counts   <= r3_cnt;
            o_net_cost <= r3_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            o_valid      <= 1'b0;
            o_total_cost <= '0;
        end else begin
            if (w_en1) r_v1 <= o_q_pop;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) begin
                o_valid <= r_v3;
                if (r_v3) begin
                    o_total_cost <= w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
                end
            end
        end
    end

endmodule

[sim/nbbc_cost_monitor.sv]
// pin and result channel monitor: predicts each net result and compares it on transfer
`timescale 1ns / 1ps

module nbbc_cost_monitor #(
    parameter int COORD_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nbbc_pkg::WGT_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [COORD_W-1:0]            i_pin_x,
    input  logic [COORD_W-1:0]            i_pin_y,
    input  logic                          i_first_pin,
    input  logic                          i_last_pin,
    input  logic                          i_net_ignored,
    input  logic                          i_pass_start,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [nbbc_pkg::SPAN_W-1:0]   i_span_x,
    input  logic [nbbc_pkg::SPAN_W-1:0]   i_span_y,
    input  logic [nbbc_pkg::COUNT_W-1:0]  i_left_count,
    input  logic [nbbc_pkg::COUNT_W-1:0]  i_right_count,
    input  logic [nbbc_pkg::COUNT_W-1:0]  i_bottom_count,
    input  logic [nbbc_pkg::COUNT_W-1:0]  i_top_count,
    input  logic [nbbc_pkg::COST_W-1:0]   i_net_cost,
    input  logic [nbbc_pkg::TOTAL_W-1:0]  i_total_cost,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int REPORT_LIMIT = 10;

    // one axis of the open box: low and high edge with their pin counts
    typedef struct packed {
        logic [COORD_W-1:0]           lo;
        logic [COORD_W-1:0]           hi;
        logic [nbbc_pkg::COUNT_W-1:0] n_lo;
        logic [nbbc_pkg::COUNT_W-1:0] n_hi;
    } t_axis;

    typedef struct packed {
        logic [nbbc_pkg::SPAN_W-1:0]  span_x;
        logic [nbbc_pkg::SPAN_W-1:0]  span_y;
        nbbc_pkg::t_counts            counts;
        logic [nbbc_pkg::COST_W-1:0]  net_cost;
        logic [nbbc_pkg::TOTAL_W-1:0] total_cost;
    } t_net_result;

    logic [nbbc_pkg::WGT_W-1:0]   weight_q88;
    t_axis                        box_x;
    t_axis                        box_y;
    logic [nbbc_pkg::TOTAL_W-1:0] total_acc;
    t_net_result                  net_results_due[$];
    int                           fail_total = 0;
    int                           due_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;

    function automatic logic [nbbc_pkg::COUNT_W-1:0] sat_inc(
        input logic [nbbc_pkg::COUNT_W-1:0] c
    );
        return (c == nbbc_pkg::COUNT_MAX) ? c : c + nbbc_pkg::COUNT_W'(1);
    endfunction

    // a pin equal to both edges bumps both counts
    function automatic t_axis axis_fold(input t_axis a, input logic [COORD_W-1:0] v);
        t_axis r;
        r = a;
        if ($signed(v) < $signed(a.lo)) begin
            r.lo   = v;
            r.n_lo = nbbc_pkg::COUNT_W'(1);
        end else if (v == a.lo) begin
            r.n_lo = sat_inc(a.n_lo);
            if (v == a.hi) begin
                r.n_hi = sat_inc(a.n_hi);
            end
        end else if ($signed(v) > $signed(a.hi)) begin
            r.hi   = v;
            r.n_hi = nbbc_pkg::COUNT_W'(1);
        end else if (v == a.hi) begin
            r.n_hi = sat_inc(a.n_hi);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_net_result                predicted;
        t_net_result                oldest;
        t_net_result                seen;
        logic [31:0]                weighted;
        logic [nbbc_pkg::TOTAL_W:0] sum;
        if (!i_rst_n) begin
            weight_q88 = nbbc_pkg::WGT_RESET;
            box_x      = '0;
            box_y      = '0;
            total_acc  = '0;
            net_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                weight_q88 = i_cfg_wdata;
            end

            if (i_out_valid && !i_out_stall) begin
                seen.span_x       = i_span_x;
                seen.span_y       = i_span_y;
                seen.counts       = '{left: i_left_count, right: i_right_count,
                                      bottom: i_bottom_count, top: i_top_count};
                seen.net_cost     = i_net_cost;
                seen.total_cost   = i_total_cost;
                if (net_results_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("%0t: result transfer with nothing expected, net_cost %0d",
                                 $time, seen.net_cost);
                    end
                end else begin
                    oldest = net_results_due.pop_front();
                    if (seen.span_x !== oldest.span_x || seen.span_y !== oldest.span_y ||
                        seen.counts !== oldest.counts || seen.net_cost !== oldest.net_cost ||
                        seen.total_cost !== oldest.total_cost) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: net result mismatch (expected / actual)", $time);
                            $display("  span_x %0d / %0d  span_y %0d / %0d",
                                     oldest.span_x, seen.span_x, oldest.span_y, seen.span_y);
                            $display("  left %0d / %0d  right %0d / %0d",
                                     oldest.counts.left, seen.counts.left,
                                     oldest.counts.right, seen.counts.right);
                            $display("  bottom %0d / %0d  top %0d / %0d",
                                     oldest.counts.bottom, seen.counts.bottom,
                                     oldest.counts.top, seen.counts.top);
                            $display("  net_cost %0d / %0d  total_cost %0d / %0d",
                                     oldest.net_cost, seen.net_cost,
                                     oldest.total_cost, seen.total_cost);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                // pass start clears the total even on an ignored pin
                if (i_pass_start) begin
                    total_acc = '0;
                end
                if (!i_net_ignored) begin
                    if (i_first_pin) begin
                        box_x = '{lo: i_pin_x, hi: i_pin_x, n_lo: nbbc_pkg::COUNT_W'(1),
                                  n_hi: nbbc_pkg::COUNT_W'(1)};
                        box_y = '{lo: i_pin_y, hi: i_pin_y, n_lo: nbbc_pkg::COUNT_W'(1),
                                  n_hi: nbbc_pkg::COUNT_W'(1)};
                    end else begin
                        box_x = axis_fold(box_x, i_pin_x);
                        box_y = axis_fold(box_y, i_pin_y);
                    end
                    if (i_last_pin) begin
                        predicted.span_x   = box_x.hi - box_x.lo;
                        predicted.span_y   = box_y.hi - box_y.lo;
                        predicted.counts   = '{left: box_x.n_lo, right: box_x.n_hi,
                                               bottom: box_y.n_lo, top: box_y.n_hi};
                        weighted           = 32'(weight_q88) * 32'(predicted.span_y);
                        predicted.net_cost = nbbc_pkg::COST_W'(predicted.span_x) +
                                             nbbc_pkg::COST_W'(weighted >> nbbc_pkg::FRAC_W);
                        sum = (nbbc_pkg::TOTAL_W + 1)'(total_acc) +
                              (nbbc_pkg::TOTAL_W + 1)'(predicted.net_cost);
                        total_acc = sum[nbbc_pkg::TOTAL_W] ? '1 : sum[nbbc_pkg::TOTAL_W-1:0];
                        predicted.total_cost = total_acc;
                        net_results_due.push_back(predicted);
                    end
                end
            end
        end
        due_count = net_results_due.size();
    end

endmodule

[sim/net_bounding_box_cost_core_tb.sv]
// stimulus and verdict for the net bounding box cost block
`timescale 1ns / 1ps

module net_bounding_box_cost_core_tb;

    localparam int COORD_W     = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [nbbc_pkg::WGT_W-1:0]    i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [COORD_W-1:0]            i_pin_x;
    logic [COORD_W-1:0]            i_pin_y;
    logic                          i_first_pin;
    logic                          i_last_pin;
    logic                          i_net_ignored;
    logic                          i_pass_start;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [nbbc_pkg::SPAN_W-1:0]   o_span_x;
    logic [nbbc_pkg::SPAN_W-1:0]   o_span_y;
    logic [nbbc_pkg::COUNT_W-1:0]  o_left_count;
    logic [nbbc_pkg::COUNT_W-1:0]  o_right_count;
    logic [nbbc_pkg::COUNT_W-1:0]  o_bottom_count;
    logic [nbbc_pkg::COUNT_W-1:0]  o_top_count;
    logic [nbbc_pkg::COST_W-1:0]   o_net_cost;
    logic [nbbc_pkg::TOTAL_W-1:0]  o_total_cost;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;

    always #5 i_clk = ~i_clk;

    net_bounding_box_cost_core #(
        .COORD_BITS (COORD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pin_x        (i_pin_x),
        .i_pin_y        (i_pin_y),
        .i_first_pin    (i_first_pin),
        .i_last_pin     (i_last_pin),
        .i_net_ignored  (i_net_ignored),
        .i_pass_start   (i_pass_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_span_x       (o_span_x),
        .o_span_y       (o_span_y),
        .o_left_count   (o_left_count),
        .o_right_count  (o_right_count),
        .o_bottom_count (o_bottom_count),
        .o_top_count    (o_top_count),
        .o_net_cost     (o_net_cost),
        .o_total_cost   (o_total_cost)
    );

    nbbc_cost_monitor #(
        .COORD_W (COORD_W)
    ) u_cost_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_pin_x        (i_pin_x),
        .i_pin_y        (i_pin_y),
        .i_first_pin    (i_first_pin),
        .i_last_pin     (i_last_pin),
        .i_net_ignored  (i_net_ignored),
        .i_pass_start   (i_pass_start),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_span_x       (o_span_x),
        .i_span_y       (o_span_y),
        .i_left_count   (o_left_count),
        .i_right_count  (o_right_count),
        .i_bottom_count (o_bottom_count),
        .i_top_count    (o_top_count),
        .i_net_cost     (o_net_cost),
        .i_total_cost   (o_total_cost),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side stalls in runs; some stretches never stall
    initial begin : out_stall_pattern
        int run_left;
        int stall_cap;
        int span_left;
        i_out_stall = 1'b0;
        run_left    = 0;
        stall_cap   = 0;
        span_left   = 0;
        forever begin
            @(negedge i_clk);
            if (span_left == 0) begin
                span_left = $urandom_range(50, 300);
                stall_cap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            span_left--;
            if (run_left == 0) begin
                if (i_out_stall || stall_cap == 0) begin
                    i_out_stall = 1'b0;
                    run_left    = $urandom_range(1, 20);
                end else begin
                    i_out_stall = 1'b1;
                    run_left    = $urandom_range(1, stall_cap);
                end
            end
            run_left--;
        end
    end

    // one pin transfer; while gaps_on is set the sender idles between bursts
    task automatic send_pin(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input bit first, input bit last, input bit ignored, input bit pass);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_pin_x       = x;
        i_pin_y       = y;
        i_first_pin   = first;
        i_last_pin    = last;
        i_net_ignored = ignored;
        i_pass_start  = pass;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold the sender until every expected result has come, then let the pipe empty
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_weight(input logic [nbbc_pkg::WGT_W-1:0] w);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = w;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // well-formed nets with random content, mixed with noise and broken nets
    task automatic run_mixed(input int n_items, input int noise_pct, input bit pause_mid);
        int           sent;
        int           len;
        int           spread;
        bit           paused;
        logic [3:0]   flags;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (pause_mid && !paused && sent >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < noise_pct) begin
                flags = 4'($urandom);
                send_pin(COORD_W'($urandom), COORD_W'($urandom),
                         flags[0], flags[1], flags[2], flags[3]);
                if (!flags[2]) begin
                    sent++;
                end
            end else begin
                len = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 3;
                    2:       spread = 15;
                    default: spread = 65535;
                endcase
                bx = COORD_W'($urandom);
                by = COORD_W'($urandom);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_pin(COORD_W'($urandom), COORD_W'($urandom), $urandom_range(0, 1),
                                 $urandom_range(0, 1), 1'b1, $urandom_range(0, 19) == 0);
                    end
                    // now and then the closing pin loses its last mark
                    send_pin(bx + COORD_W'($urandom_range(0, spread)),
                             by + COORD_W'($urandom_range(0, spread)),
                             k == 0, (k == len - 1) && ($urandom_range(0, 9) != 0),
                             1'b0, $urandom_range(0, 19) == 0);
                    sent++;
                end
            end
        end
    endtask

    // two-pin nets spanning the full y range, and mostly the full x range, so the total runs into saturation
    task automatic run_total_saturation(input int n_nets);
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        for (int n = 0; n < n_nets; n++) begin
            ax = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            ay = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            send_pin(ax, ay, 1'b1, 1'b0, 1'b0, n == 0);
            if ($urandom_range(0, 7) == 0) begin
                send_pin(COORD_W'($urandom), COORD_W'($urandom), 1'b0, 1'b1, 1'b1, 1'b0);
            end
            ax = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom) : ~ax;
            send_pin(ax, ~ay, 1'b0, 1'b1, 1'b0, 1'b0);
        end
    endtask

    // one net with every pin on a single point keeps all four counts climbing together
    task automatic run_long_net(input int n_pins);
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        px = COORD_W'($urandom);
        py = COORD_W'($urandom);
        for (int k = 0; k < n_pins; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_pin(COORD_W'($urandom), COORD_W'($urandom), $urandom_range(0, 1),
                         $urandom_range(0, 1), 1'b1, 1'b0);
            end
            send_pin(px, py, k == 0, k == n_pins - 1, 1'b0, 1'b0);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_pin_x       = '0;
        i_pin_y       = '0;
        i_first_pin   = 1'b0;
        i_last_pin    = 1'b0;
        i_net_ignored = 1'b0;
        i_pass_start  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // pins with no open net fold into the zero box left by reset
        send_pin(16'd5, -16'sd3, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pin(16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
        // single-pin net
        send_pin(16'd100, -16'sd100, 1'b1, 1'b1, 1'b0, 1'b0);
        // coordinate extremes
        send_pin(16'h8000, 16'h8000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pin(16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pin(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0, 1'b0);
        // box collapsed to a point: each pin lands on both edges of each axis
        send_pin(16'd7, 16'd7, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pin(16'd7, 16'd7, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pin(16'd7, 16'd7, 1'b0, 1'b1, 1'b0, 1'b0);
        // ignored pins, one clearing the total, inside an open net
        send_pin(16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pin(16'd1000, 16'd1000, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pin(16'd2000, -16'sd2000, 1'b1, 1'b1, 1'b1, 1'b0);
        send_pin(16'd10, 16'd20, 1'b0, 1'b1, 1'b0, 1'b0);
        // new low and high edges restart their counts
        send_pin(16'd10, 16'd10, 1'b1, 1'b0, 1'b0, 1'b0);
        send_pin(16'd10, 16'd10, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pin(16'd5, 16'd15, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pin(16'd20, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0);
        send_pin(16'd5, 16'd5, 1'b0, 1'b1, 1'b0, 1'b0);
        // closed net reopened by a pin without a first mark
        send_pin(16'd3, 16'd3, 1'b0, 1'b1, 1'b0, 1'b0);
        // total cleared on a counted pin
        send_pin(16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1);
        send_pin(16'd1, 16'd1, 1'b0, 1'b1, 1'b0, 1'b0);

        write_weight(16'd0);
        run_mixed(150, 10, 1'b0);

        write_weight(16'hFFFF);
        gaps_on = 1'b0;
        run_mixed(150, 10, 1'b0);
        gaps_on = 1'b1;

        write_weight(nbbc_pkg::WGT_W'($urandom));
        run_mixed(150, 15, 1'b1);

        write_weight(16'hFFFF);
        run_total_saturation(270);

        write_weight(16'd1);
        run_long_net(320);

        write_weight(nbbc_pkg::WGT_RESET);
        run_mixed(300, 20, 1'b0);

        wait_drained();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[net_bounding_box_cost_core.f]
sv/nbbc_pkg.sv
sv/nbbc_front.sv
sv/nbbc_queue.sv
sv/nbbc_back.sv
sv/net_bounding_box_cost_core.sv
sim/nbbc_cost_monitor.sv
sim/net_bounding_box_cost_core_tb.sv
